// File: design/pdfm_pkg.sv
// Package for the PWM duty and frequency monitor.
// Holds widths, constants, the controller state type and the divider request types.
// No dependencies; every other file of the block imports it.
package pdfm_pkg;

	// Field widths.
	localparam int unsigned HALF_W = 16;
	localparam int unsigned TS_W = 2 * HALF_W;
	localparam int unsigned TICK_W = 27;
	localparam int unsigned DUTY_W = 9;
	localparam int unsigned DUTY_FRAC_BITS = DUTY_W - 1;

	// Default channel count for the top level.
	localparam int unsigned NUM_CHANNELS_DEF = 2;

	// Constants of the measurement.
	localparam logic [DUTY_W-1:0] DUTY_SCALE = DUTY_W'(256);
	localparam logic [TICK_W-1:0] TICK_RESET = TICK_W'(36000000);

	// The serial divider produces one quotient bit per step.
	localparam int unsigned QUO_W = TICK_W;
	localparam int unsigned STEP_W = $clog2(QUO_W + 1);
	localparam logic [STEP_W-1:0] DUTY_STEPS = STEP_W'(DUTY_FRAC_BITS);
	localparam logic [STEP_W-1:0] FREQ_STEPS = STEP_W'(QUO_W);

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP,
		ST_DIFF,
		ST_SAT,
		ST_DUTY,
		ST_FREQ,
		ST_DONE
	} state_t;

	// Request to the serial divider.
	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [TS_W-1:0]   divisor;
		logic [TS_W-1:0]   rem_init;
		logic [QUO_W-1:0]  num_init;
	} div_req_t;

	// Response of the serial divider.
	typedef struct packed {
		logic             done;
		logic [QUO_W-1:0] quotient;
	} div_rsp_t;

endpackage

// File: design/pdfm_ifs.sv
// Channel interfaces of the PWM duty and frequency monitor.
// Edge events in, measurement reports out, and the tick rate write channel.
// Depends on pdfm_pkg for field widths.
interface pdfm_evt_if;
	import pdfm_pkg::*;

	logic              valid;
	logic              ready;
	logic              channel;
	logic              falling_edge;
	logic [HALF_W-1:0] overflow_count;
	logic [HALF_W-1:0] capture_value;

	modport source (
		output valid, channel, falling_edge, overflow_count, capture_value,
		input  ready
	);
	modport sink (
		input  valid, channel, falling_edge, overflow_count, capture_value,
		output ready
	);
endinterface

interface pdfm_rpt_if;
	import pdfm_pkg::*;

	logic              valid;
	logic              ready;
	logic              report_channel;
	logic              measure_valid;
	logic [DUTY_W-1:0] duty_fraction;
	logic [TICK_W-1:0] frequency_hz;

	modport source (
		output valid, report_channel, measure_valid, duty_fraction, frequency_hz,
		input  ready
	);
	modport sink (
		input  valid, report_channel, measure_valid, duty_fraction, frequency_hz,
		output ready
	);
endinterface

interface pdfm_cfg_if;
	import pdfm_pkg::*;

	logic              valid;
	logic              ready;
	logic [TICK_W-1:0] data;

	modport source (
		output valid, data,
		input  ready
	);
	modport sink (
		input  valid, data,
		output ready
	);
endinterface

// File: design/pdfm_div.sv
// Bit-serial restoring divider of the PWM monitor.
// One quotient bit per cycle; dividend bits and quotient bits share one shift register.
// Depends on pdfm_pkg for widths and the request and response structs.
module pdfm_div (
	input  logic               clk,
	input  logic               arst_n,
	input  pdfm_pkg::div_req_t req,
	output pdfm_pkg::div_rsp_t rsp
);
	import pdfm_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [STEP_W-1:0] cnt_q;
	logic [TS_W-1:0]   dvs_q;
	logic [TS_W-1:0]   rem_q;
	logic [QUO_W-1:0]  num_q;

	logic [TS_W:0]     trial;
	logic [TS_W:0]     diff;
	logic              ge;
	logic [TS_W-1:0]   rem_next;

	// One restoring step: bring down the next dividend bit and try the subtract.
	// The remainder stays below the divisor, so the trial value fits one extra bit.
	assign trial    = {rem_q, num_q[QUO_W-1]};
	assign diff     = trial - {1'b0, dvs_q};
	assign ge       = trial >= {1'b0, dvs_q};
	assign rem_next = ge ? diff[TS_W-1:0] : trial[TS_W-1:0];

	// Step counter and completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Remainder and dividend/quotient shift register.
	always_ff @(posedge clk) begin
		if (req.start) begin
			dvs_q <= req.divisor;
			rem_q <= req.rem_init;
			num_q <= req.num_init;
		end else if (busy_q) begin
			rem_q <= rem_next;
			num_q <= {num_q[QUO_W-2:0], ge};
		end
	end

	assign rsp.done     = done_q;
	assign rsp.quotient = num_q;

endmodule

// File: design/pwm_duty_frequency_monitor_unit.sv
// Top level of the PWM duty and frequency monitor.
// Keeps the edge timestamps per channel and sequences the serial divider.
// Depends on pdfm_pkg, the channel interfaces and pdfm_div.
//
//   channel  dir  payload                                                  transfer when
//   evt      in   channel, falling_edge, overflow_count, capture_value     valid & ready
//   cfg      in   data (tick rate in hertz)                                valid & ready
//   rpt      out  report_channel, measure_valid, duty_fraction, frequency  valid & ready
//
// An invalid measurement goes straight to the report; a valid one runs the shared
// bit-serial divider for 8 duty steps and then 27 frequency steps, or for the frequency
// steps alone when duty saturates. One edge is worked on at a time.
// Reset clears all timestamps and loads the tick rate with 36000000.
// A finished report sits in the output register, so the next edge is taken while it waits;
// a stalled report holds the controller only when the following one is ready.
module pwm_duty_frequency_monitor_unit #(
	parameter int unsigned NUM_CHANNELS = pdfm_pkg::NUM_CHANNELS_DEF
) (
	input logic clk,
	input logic arst_n,
	pdfm_evt_if.sink   evt,
	pdfm_cfg_if.sink   cfg,
	pdfm_rpt_if.source rpt
);
	import pdfm_pkg::*;

	localparam int unsigned CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	state_t state_q, state_d;

	// Timestamp store, one entry per channel.
	logic [TS_W-1:0] rise_prev_q [NUM_CHANNELS];
	logic [TS_W-1:0] rise_lat_q  [NUM_CHANNELS];
	logic [TS_W-1:0] fall_prev_q [NUM_CHANNELS];
	logic [TS_W-1:0] fall_lat_q  [NUM_CHANNELS];

	logic [TICK_W-1:0] tick_q;

	logic              ch_q;
	logic              ch_ok_q;
	logic [CH_W-1:0]   idx_q;
	logic              valid_q;
	logic              fall_last_q;
	logic [TS_W-1:0]   period_q;
	logic [TS_W-1:0]   high_q;
	logic [DUTY_W-1:0] duty_q;
	logic [TICK_W-1:0] freq_q;

	logic              rpt_valid_q;
	logic              rpt_ch_q;
	logic              rpt_meas_q;
	logic [DUTY_W-1:0] rpt_duty_q;
	logic [TICK_W-1:0] rpt_freq_q;

	logic              evt_take;
	logic              ch_ok;
	logic [CH_W-1:0]   idx;
	logic [TS_W-1:0]   stamp;
	logic [TS_W-1:0]   rp, rl, fp, fl;
	logic              sat;
	logic              out_load;
	div_req_t          div_req;
	div_rsp_t          div_rsp;

	// Incoming edge decode.
	assign evt_take = evt.valid && evt.ready;
	assign ch_ok    = 32'(evt.channel) < NUM_CHANNELS;
	assign idx      = ch_ok ? CH_W'(evt.channel) : '0;
	assign stamp    = {evt.overflow_count, evt.capture_value};

	// Timestamps of the channel being measured.
	assign rp  = rise_prev_q[idx_q];
	assign rl  = rise_lat_q[idx_q];
	assign fp  = fall_prev_q[idx_q];
	assign fl  = fall_lat_q[idx_q];
	assign sat = high_q >= period_q;

	// Tick rate register; the write channel never stalls.
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q <= TICK_RESET;
		end else if (cfg.valid && cfg.ready) begin
			tick_q <= cfg.data;
		end
	end

	// Timestamp store: shift latest into previous for the edge's polarity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				rise_prev_q[i] <= '0;
				rise_lat_q[i]  <= '0;
				fall_prev_q[i] <= '0;
				fall_lat_q[i]  <= '0;
			end
		end else if (evt_take && ch_ok) begin
			if (evt.falling_edge) begin
				fall_prev_q[idx] <= fall_lat_q[idx];
				fall_lat_q[idx]  <= stamp;
			end else begin
				rise_prev_q[idx] <= rise_lat_q[idx];
				rise_lat_q[idx]  <= stamp;
			end
		end
	end

	// Controller state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (evt_take) state_d = ST_CMP;
			end
			ST_CMP: begin
				state_d = ST_DIFF;
			end
			ST_DIFF: begin
				state_d = valid_q ? ST_SAT : ST_DONE;
			end
			ST_SAT: begin
				state_d = sat ? ST_FREQ : ST_DUTY;
			end
			ST_DUTY: begin
				if (div_rsp.done) state_d = ST_FREQ;
			end
			ST_FREQ: begin
				if (div_rsp.done) state_d = ST_DONE;
			end
			ST_DONE: begin
				if (!rpt_valid_q || rpt.ready) state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Controller outputs: input ready, divider requests and the report load.
	always_comb begin
		evt.ready        = 1'b0;
		out_load         = 1'b0;
		div_req.start    = 1'b0;
		div_req.steps    = FREQ_STEPS;
		div_req.divisor  = period_q;
		div_req.rem_init = '0;
		div_req.num_init = tick_q;
		unique case (state_q)
			ST_IDLE: begin
				evt.ready = 1'b1;
			end
			ST_SAT: begin
				div_req.start = 1'b1;
				if (!sat) begin
					div_req.steps    = DUTY_STEPS;
					div_req.rem_init = high_q;
					div_req.num_init = '0;
				end
			end
			ST_DUTY: begin
				div_req.start = div_rsp.done;
			end
			ST_DONE: begin
				out_load = !rpt_valid_q || rpt.ready;
			end
			default: begin
			end
		endcase
	end

	// Measurement datapath registers.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (evt_take) begin
					ch_q    <= evt.channel;
					ch_ok_q <= ch_ok;
					idx_q   <= idx;
				end
			end
			ST_CMP: begin
				valid_q     <= ch_ok_q && (fp < fl) && (rp < rl);
				fall_last_q <= fl > rl;
			end
			ST_DIFF: begin
				period_q <= fall_last_q ? (fl - fp) : (rl - rp);
				high_q   <= fall_last_q ? (fl - rl) : (fl - rp);
				duty_q   <= '0;
				freq_q   <= '0;
			end
			ST_SAT: begin
				if (sat) duty_q <= DUTY_SCALE;
			end
			ST_DUTY: begin
				if (div_rsp.done) begin
					duty_q <= {1'b0, div_rsp.quotient[DUTY_FRAC_BITS-1:0]};
				end
			end
			ST_FREQ: begin
				if (div_rsp.done) freq_q <= div_rsp.quotient[TICK_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// Shared serial divider for duty and frequency.
	pdfm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Report output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpt_valid_q <= 1'b0;
		end else begin
			if (rpt.valid && rpt.ready) rpt_valid_q <= 1'b0;
			if (out_load) rpt_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			rpt_ch_q   <= ch_q;
			rpt_meas_q <= valid_q;
			rpt_duty_q <= duty_q;
			rpt_freq_q <= freq_q;
		end
	end

	assign rpt.valid          = rpt_valid_q;
	assign rpt.report_channel = rpt_ch_q;
	assign rpt.measure_valid  = rpt_meas_q;
	assign rpt.duty_fraction  = rpt_duty_q;
	assign rpt.frequency_hz   = rpt_freq_q;

endmodule

// File: design/pdfm_chk.sv
// Port-level checker of the PWM duty and frequency monitor, bound to the top level.
// Watches the event and report channels over time.
// Depends on pdfm_pkg for field widths.
module pdfm_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        evt_valid,
	input logic                        evt_ready,
	input logic                        rpt_valid,
	input logic                        rpt_ready,
	input logic                        rpt_meas,
	input logic [pdfm_pkg::DUTY_W-1:0] rpt_duty,
	input logic [pdfm_pkg::TICK_W-1:0] rpt_freq
);
	import pdfm_pkg::*;

	// One edge is worked on at a time: a transfer closes the input.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid && evt_ready |=> !evt_ready)
		else $error("event taken while a previous one is still being measured");

	// A new report only follows a cycle in which the input was closed.
	a_report_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rpt_valid) |-> $past(!evt_ready))
		else $error("report appeared without a measurement in progress");

	// A stalled report holds its contents.
	a_report_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rpt_valid && !rpt_ready |=>
			rpt_valid && $stable(rpt_meas) && $stable(rpt_duty) && $stable(rpt_freq))
		else $error("stalled report changed");

endmodule

bind pwm_duty_frequency_monitor_unit pdfm_chk u_pdfm_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.evt_valid (evt.valid),
	.evt_ready (evt.ready),
	.rpt_valid (rpt.valid),
	.rpt_ready (rpt.ready),
	.rpt_meas  (rpt.measure_valid),
	.rpt_duty  (rpt.duty_fraction),
	.rpt_freq  (rpt.frequency_hz)
);
